// File: rtl/pulse_pri_track_deinterleaver_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse deinterleaver
// Immediate-cycle and next-cycle property checks, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef PULSE_PRI_TRACK_DEINTERLEAVER_UNIT_DEFINES_SVH
`define PULSE_PRI_TRACK_DEINTERLEAVER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PPT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PPT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PPT_ASSERT_IMP(lbl, ante, cons)
`define PPT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// Pulse deinterleaver package
// Field widths, defaults and codes shared by the deinterleaver files.
// ----------------------------------------------------------------------------
package ppt_pkg;
	localparam int PPT_MAX_TRACKS  = 32;
	localparam int PPT_SAMPLE_BITS = 48;
	localparam int PPT_FRAC_BITS   = 8;

	localparam int IN_SAMPLE_W = 48;
	localparam int PEAK_W      = 16;
	localparam int CNT_W       = 24;
	localparam int PSUM_W      = 40;
	localparam int TOL_W       = 24;
	localparam int ID_W        = 5;
	localparam int PRI_W       = 56;
	localparam int MPK_W       = 24;

	localparam logic [TOL_W-1:0] TOL_RESET = 24'd100;

	localparam logic ACT_PULSE  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;
endpackage

// File: rtl/pulse_pri_track_deinterleaver_unit.sv
// ----------------------------------------------------------------------------
// Pulse PRI track deinterleaver
// Assigns pulse events to emitter tracks and reports per-track statistics.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A pulse event scans
// the track table held in one synchronous RAM, picks a target track, then
// runs two serial dividers to refresh the stored mean interval and mean peak
// before writing the record back. A pulse that opens a new track skips the
// record fetch, and a dropped pulse ends after the scan. A report keeps
// busy high while it reads the table and gives one result beat per cycle,
// one per track in use, the first after the RAM read and the output
// register; an empty report gives a single beat in the cycle after
// acceptance and leaves busy low. Result beats are marked by result_strobe
// for one cycle and cannot be held off. The tolerance register is written
// through cfg_we and cfg_wdata; the user is to write it only while idle,
// as the block does not enforce this. Reset empties the table, clears
// the drop flag and sets the tolerance to 100 samples; no clearing pass is
// needed since new tracks are written whole before use.
// ----------------------------------------------------------------------------
`include "pulse_pri_track_deinterleaver_unit_defines.svh"

module pulse_pri_track_deinterleaver_unit import ppt_pkg::*; #(
	parameter int MAX_TRACKS  = PPT_MAX_TRACKS,
	parameter int SAMPLE_BITS = PPT_SAMPLE_BITS,
	parameter int FRAC_BITS   = PPT_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   action,
	input  logic [IN_SAMPLE_W-1:0] pulse_time,
	input  logic [PEAK_W-1:0]      pulse_peak,
	input  logic                   cfg_we,
	input  logic [TOL_W-1:0]       cfg_wdata,
	output logic                   result_strobe,
	output logic [ID_W-1:0]        trk_num,
	output logic [CNT_W-1:0]       pulse_total,
	output logic [PRI_W-1:0]       mean_pri_q8,
	output logic [MPK_W-1:0]       mean_peak_q8,
	output logic                   no_tracks,
	output logic                   pulses_dropped,
	output logic                   last
);
	localparam int S   = SAMPLE_BITS;
	localparam int F   = FRAC_BITS;
	localparam int QW  = S + F;
	localparam int DQ  = QW + 1;
	localparam int KW  = PSUM_W + F;
	localparam int AW  = $clog2(MAX_TRACKS);
	localparam int CW  = $clog2(MAX_TRACKS + 1);

	typedef struct packed {
		logic [S-1:0]      last_start;
		logic [S-1:0]      isum;
		logic [CNT_W-1:0]  icnt;
		logic [CNT_W-1:0]  pcnt;
		logic [PSUM_W-1:0] psum;
		logic [QW-1:0]     mpri;
		logic [MPK_W-1:0]  mpk;
	} trk_t;

	localparam int RW = $bits(trk_t);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_FETCH, ST_LOAD, ST_UPD,
		ST_DIVGO, ST_DIVWAIT, ST_WRITE, ST_REPORT, ST_RDRAIN
	} state_t;

	state_t            state_q;
	logic [TOL_W-1:0]  tol_q;
	logic [CW-1:0]     tracks_q;
	logic              drop_q;
	logic [S-1:0]      start_q;
	logic [PEAK_W-1:0] peak_q;
	logic [CW-1:0]     scan_idx_q;
	logic [CW-1:0]     rep_idx_q;
	logic [AW-1:0]     tgt_q;
	trk_t              cur_q;
	trk_t              upd_q;
	logic [DQ-1:0]     best_d_q;
	logic [AW-1:0]     best_q;
	logic              best_v_q;
	logic [AW-1:0]     seed_q;
	logic              seed_v_q;

	logic              scan_v_s1;
	logic [AW-1:0]     scan_idx_s1;
	logic              v_s2;
	logic [AW-1:0]     idx_s2;
	logic              haspri_s2;
	logic              one_s2;
	logic              ahead_s2;
	logic [QW-1:0]     dq_s2;
	logic [QW-1:0]     m_s2;
	logic              v_s3;
	logic [AW-1:0]     idx_s3;
	logic              haspri_s3;
	logic              one_s3;
	logic [DQ-1:0]     dist_s3;

	logic              rep_v_s1;
	logic [AW-1:0]     rep_idx_s1;
	logic              rep_last_s1;

	logic              strobe_q;
	logic [ID_W-1:0]   id_q;
	logic [CNT_W-1:0]  total_q;
	logic [PRI_W-1:0]  pri_q;
	logic [MPK_W-1:0]  mpk_q;
	logic              empty_q;
	logic              last_q;

	logic              accept;
	logic              empty_rep;
	logic              scan_issue;
	logic              scan_done;
	logic [AW-1:0]     raddr;
	logic [RW-1:0]     rdata;
	trk_t              rd;
	logic              mem_we;
	trk_t              wrec;
	trk_t              upd_nxt;
	logic [S-1:0]      gap_abs;
	logic              ahead;
	logic [QW-1:0]     m_minus;
	logic [S-1:0]      gap_pos;
	logic [S:0]        isum_add;
	logic [PSUM_W:0]   psum_add;
	logic              div_go;
	logic              pri_ready;
	logic              pk_ready;
	logic [QW-1:0]     pri_quo;
	logic [KW-1:0]     pk_quo;

	assign accept     = start && !busy;
	assign busy       = state_q != ST_IDLE;
	assign empty_rep  = accept && action == ACT_REPORT && tracks_q == '0;
	assign rd         = trk_t'(rdata);
	assign scan_issue = state_q == ST_SCAN && scan_idx_q != tracks_q;
	assign scan_done  = state_q == ST_SCAN && scan_idx_q == tracks_q
		&& !scan_v_s1 && !v_s2 && !v_s3;
	assign div_go     = state_q == ST_DIVGO;
	assign mem_we     = state_q == ST_WRITE;

	always_comb begin
		priority if (state_q == ST_REPORT) begin
			raddr = rep_idx_q[AW-1:0];
		end else if (state_q == ST_FETCH) begin
			raddr = tgt_q;
		end else begin
			raddr = scan_idx_q[AW-1:0];
		end
	end

	always_comb begin
		wrec      = upd_q;
		wrec.mpri = (upd_q.icnt == '0) ? '0 : pri_quo;
		wrec.mpk  = ((pk_quo >> MPK_W) != '0) ? '1 : MPK_W'(pk_quo);
	end

	ppt_trk_mem #(.DEPTH(MAX_TRACKS), .WIDTH(RW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tgt_q),
		.wdata (wrec),
		.raddr (raddr),
		.rdata (rdata)
	);

	ppt_div #(.DW(QW), .VW(CNT_W)) u_div_pri (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (QW'(upd_q.isum) << F),
		.divisor  (upd_q.icnt),
		.ready    (pri_ready),
		.quotient (pri_quo)
	);

	ppt_div #(.DW(KW), .VW(CNT_W)) u_div_pk (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (KW'(upd_q.psum) << F),
		.divisor  (upd_q.pcnt),
		.ready    (pk_ready),
		.quotient (pk_quo)
	);

	// Scan pipeline: RAM read, offset from the last start, distance, compare.
	assign ahead   = start_q >= rd.last_start;
	assign gap_abs = ahead ? start_q - rd.last_start : rd.last_start - start_q;
	assign m_minus = (m_s2 >= dq_s2) ? m_s2 - dq_s2 : dq_s2 - m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			rep_v_s1  <= 1'b0;
		end else begin
			scan_v_s1 <= scan_issue;
			v_s2      <= scan_v_s1;
			v_s3      <= v_s2;
			rep_v_s1  <= state_q == ST_REPORT;
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q[AW-1:0];
		idx_s2      <= scan_idx_s1;
		haspri_s2   <= rd.icnt != '0;
		one_s2      <= rd.pcnt == CNT_W'(1);
		ahead_s2    <= ahead;
		dq_s2       <= QW'(gap_abs) << F;
		m_s2        <= rd.mpri;
		idx_s3      <= idx_s2;
		haspri_s3   <= haspri_s2;
		one_s3      <= one_s2;
		dist_s3     <= ahead_s2 ? DQ'(m_minus) : DQ'(m_s2) + DQ'(dq_s2);
		rep_idx_s1  <= rep_idx_q[AW-1:0];
		rep_last_s1 <= rep_idx_q + 1'b1 == tracks_q;
	end

	assign gap_pos  = (start_q > cur_q.last_start) ? start_q - cur_q.last_start : '0;
	assign isum_add = {1'b0, cur_q.isum} + {1'b0, gap_pos};
	assign psum_add = {1'b0, cur_q.psum} + (PSUM_W + 1)'(peak_q);

	always_comb begin
		upd_nxt            = cur_q;
		upd_nxt.last_start = start_q;
		if (cur_q.pcnt != '0) begin
			upd_nxt.isum = isum_add[S] ? '1 : isum_add[S-1:0];
			if (cur_q.icnt != '1) begin
				upd_nxt.icnt = cur_q.icnt + 1'b1;
			end
		end
		upd_nxt.psum = psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
		if (cur_q.pcnt != '1) begin
			upd_nxt.pcnt = cur_q.pcnt + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tol_q      <= TOL_RESET;
			tracks_q   <= '0;
			drop_q     <= 1'b0;
			scan_idx_q <= '0;
			rep_idx_q  <= '0;
			best_v_q   <= 1'b0;
			seed_v_q   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= rep_v_s1 || empty_rep;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (v_s3) begin
				if (haspri_s3) begin
					if (dist_s3 <= best_d_q) begin
						best_d_q <= dist_s3;
						best_q   <= idx_s3;
						best_v_q <= 1'b1;
					end
				end else if (one_s3 && !seed_v_q) begin
					seed_q   <= idx_s3;
					seed_v_q <= 1'b1;
				end
			end
			if (rep_v_s1) begin
				id_q     <= ID_W'(rep_idx_s1);
				total_q  <= rd.pcnt;
				pri_q    <= ((rd.mpri >> PRI_W) != '0) ? '1 : PRI_W'(rd.mpri);
				mpk_q    <= rd.mpk;
				empty_q  <= 1'b0;
				last_q   <= rep_last_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q <= S'(pulse_time);
						peak_q  <= pulse_peak;
						if (action == ACT_PULSE) begin
							scan_idx_q <= '0;
							best_d_q   <= DQ'(tol_q) << F;
							best_v_q   <= 1'b0;
							seed_v_q   <= 1'b0;
							state_q    <= ST_SCAN;
						end else if (tracks_q == '0) begin
							id_q     <= '0;
							total_q  <= '0;
							pri_q    <= '0;
							mpk_q    <= '0;
							empty_q  <= 1'b1;
							last_q   <= 1'b1;
						end else begin
							rep_idx_q <= '0;
							state_q   <= ST_REPORT;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (best_v_q) begin
						tgt_q   <= best_q;
						state_q <= ST_FETCH;
					end else if (seed_v_q) begin
						tgt_q   <= seed_q;
						state_q <= ST_FETCH;
					end else if (tracks_q == CW'(MAX_TRACKS)) begin
						drop_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						tgt_q    <= tracks_q[AW-1:0];
						tracks_q <= tracks_q + 1'b1;
						cur_q    <= '0;
						state_q  <= ST_UPD;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cur_q   <= rd;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					upd_q   <= upd_nxt;
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (pri_ready && pk_ready) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_REPORT: begin
					rep_idx_q <= rep_idx_q + 1'b1;
					if (rep_idx_q + 1'b1 == tracks_q) begin
						state_q <= ST_RDRAIN;
					end
				end
				ST_RDRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe  = strobe_q;
	assign trk_num        = id_q;
	assign pulse_total    = total_q;
	assign mean_pri_q8    = pri_q;
	assign mean_peak_q8   = mpk_q;
	assign no_tracks      = empty_q;
	assign pulses_dropped = drop_q;
	assign last           = last_q;

	`PPT_ASSERT_IMP(a_empty_is_last, strobe_q && empty_q, last_q)
	`PPT_ASSERT_NXT(a_drop_sticky, drop_q, drop_q)
	`PPT_ASSERT_NXT(a_pulse_quiet, accept && action == ACT_PULSE, !strobe_q)
endmodule

// File: rtl/ppt_trk_mem.sv
// ----------------------------------------------------------------------------
// Track table memory
// Single-port-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ppt_trk_mem import ppt_pkg::*; #(
	parameter int DEPTH = PPT_MAX_TRACKS,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppt_div import ppt_pkg::*; #(
	parameter int DW = 56,
	parameter int VW = CNT_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          ready,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign ready    = cnt_q == '0;
	assign quotient = quo_q;
endmodule
